// ----- hdl/cmea_pkg.sv -----
package cmea_pkg;

  localparam int MaxSizeDefault = 64;
  localparam int DataW = 32;
  localparam int AccW = 64;
  localparam int CfgIdxW = 2;
  localparam int ActW = 7;

  localparam logic [CfgIdxW-1:0] CfgGain = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScale = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSize = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Raw Q16.16 value of the -10.0 offset on the (0,0) entry.
  localparam logic signed [AccW-1:0] DiagZeroOffset = -64'sd655360;

  // One classified word passed from the front end to the back end.
  typedef struct packed {
    logic       op;
    logic [5:0] row;
    logic [5:0] col;
    logic [31:0] inter;
    logic [31:0] weight;
    logic       flag;
    logic       fin;
  } cmea_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_TERM,
    ST_MUL,
    ST_SCALE,
    ST_OUT
  } cmea_state_t;

  // Saturates a signed value to the signed 32-bit range. Floor shift of a signed value is an arithmetic shift.
  function automatic logic signed [AccW-1:0] sat32(input logic signed [95:0] v);
    logic signed [95:0] hi;
    logic signed [95:0] lo;
    begin
      hi = 96'sd2147483647;
      lo = -96'sd2147483648;
      if (v > hi) sat32 = 64'sd2147483647;
      else if (v < lo) sat32 = -64'sd2147483648;
      else sat32 = v[AccW-1:0];
    end
  endfunction

endpackage

// ----- hdl/contact_matrix_entry_assembly.sv -----
// Contact matrix entry assembly. Input words (tdata: op, row_index, col_index,
// interaction_value, weight_value, neighbor_flag; tlast: final_pair) either load one
// cell of the interaction, weight and flag stores or query one symmetric matrix entry.
// A load writes its cell in the back end and gives no result. An off-diagonal query
// reads two cells; a diagonal query reads two cells per column over one store
// port, for every column below active_size. A two-word queue in front lets loads
// and queries be accepted while a result waits on the output. Stores are not cleared
// after reset; a cell must be loaded before any query reads it.
module contact_matrix_entry_assembly import cmea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op, row_index, col_index, interaction_value, weight_value, neighbor_flag
  input  logic [79:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // row_out, col_out, matrix_value
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_wdata
);

  logic signed [31:0] gain_r, scale_r;
  logic [ActW-1:0] act_r;
  logic q_valid, q_pop;
  cmea_cmd_t q_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      scale_r <= 32'sd65536;
      act_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgGain: gain_r <= cfg_wdata;
        CfgScale: scale_r <= cfg_wdata;
        CfgSize: act_r <= cfg_wdata[ActW-1:0];
        default: ;
      endcase
    end
  end

  cmea_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_valid, .q_pop, .q_cmd);

  cmea_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .gain(gain_r), .scale(scale_r), .act_size(act_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast);

endmodule

// ----- hdl/cmea_ram.sv -----
module cmea_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cmea_front.sv -----
module cmea_front import cmea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        in_tlast,
  output logic        q_valid,
  input  logic        q_pop,
  output cmea_cmd_t   q_cmd
);

  // Two-entry queue of decoded words.
  cmea_cmd_t  buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmea_cmd_t  cmd;

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = buf_r[rp_r];

  // Unpack the input word into its fields.
  always_comb begin
    cmd.op     = in_tdata[0];
    cmd.row    = in_tdata[6:1];
    cmd.col    = in_tdata[12:7];
    cmd.inter  = in_tdata[44:13];
    cmd.weight = in_tdata[76:45];
    cmd.flag   = in_tdata[77];
    cmd.fin    = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_tready) else $error("full queue accepted a word");

endmodule

// ----- hdl/cmea_back.sv -----
module cmea_back import cmea_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  cmea_cmd_t   q_cmd,
  input  logic signed [31:0] gain,
  input  logic signed [31:0] scale,
  input  logic [ActW-1:0]    act_size,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  localparam int MaxSize = MaxSizeDefault;
  localparam int IdxW = $clog2(MaxSize);
  localparam int AddrW = 2 * IdxW;
  localparam int CntW = IdxW + 1;

  cmea_state_t state_r, state_nxt;
  cmea_cmd_t   cmd_r;
  logic [CntW-1:0] act_r;
  logic [CntW-1:0] l_r;
  logic        phase_r;
  logic        in_range_r;
  logic signed [AccW-1:0] acc_r;
  logic signed [AccW-1:0] val_r;
  logic [IdxW-1:0] ti_r, tj_r;
  logic rd_v_r;
  logic [31:0] inter_q, weight_q;
  logic [0:0] flag_q;
  logic [AddrW-1:0] raddr, waddr;
  logic [IdxW-1:0] ri, rj;
  logic we;
  logic signed [AccW-1:0] term;
  logic signed [63:0] p_gain, p_iw;
  logic signed [64:0] p_lo;
  logic signed [64:0] plo_r;
  logic signed [63:0] p_hi;
  logic signed [95:0] p_full;
  logic last_rd;
  logic diag;
  logic [CntW-1:0] act_clip;

  assign diag = (cmd_r.row == cmd_r.col);
  assign act_clip = (act_size > ActW'(MaxSize)) ? CntW'(MaxSize) : act_size[CntW-1:0];

  // Load writes go straight into the three stores.
  assign we = q_pop && (q_cmd.op == OpLoad) && ({2'b0, q_cmd.row} < 8'(MaxSize))
              && ({2'b0, q_cmd.col} < 8'(MaxSize));
  assign waddr = {q_cmd.row[IdxW-1:0], q_cmd.col[IdxW-1:0]};

  // Read address: diagonal sweeps (d,l) then (l,d); off-diagonal reads (r,c), (c,r).
  always_comb begin
    if (diag) begin
      ri = phase_r ? l_r[IdxW-1:0] : cmd_r.row[IdxW-1:0];
      rj = phase_r ? cmd_r.row[IdxW-1:0] : l_r[IdxW-1:0];
    end else begin
      ri = phase_r ? cmd_r.col[IdxW-1:0] : cmd_r.row[IdxW-1:0];
      rj = phase_r ? cmd_r.row[IdxW-1:0] : cmd_r.col[IdxW-1:0];
    end
  end
  assign raddr = {ri, rj};
  assign last_rd = diag ? (phase_r && (l_r == act_r - CntW'(1))) : phase_r;

  cmea_ram #(.Width(32), .Depth(MaxSize*MaxSize)) u_inter (
    .clk, .we, .waddr, .wdata(q_cmd.inter), .raddr, .rdata(inter_q));
  cmea_ram #(.Width(32), .Depth(MaxSize*MaxSize)) u_weight (
    .clk, .we, .waddr, .wdata(q_cmd.weight), .raddr, .rdata(weight_q));
  cmea_ram #(.Width(1), .Depth(MaxSize*MaxSize)) u_flag (
    .clk, .we, .waddr, .wdata(q_cmd.flag), .raddr, .rdata(flag_q));

  // Pair term of the cell read last cycle.
  assign p_gain = 64'(gain) * 64'($signed(inter_q));
  assign p_iw = 64'($signed(inter_q)) * 64'($signed(weight_q));
  always_comb begin
    term = '0;
    if ({1'b0, tj_r} == {1'b0, ti_r} + 1'b1 && flag_q[0]) term = p_gain >>> 16;
    if (({1'b0, ti_r} != {1'b0, tj_r} + 1'b1) && ({1'b0, tj_r} != {1'b0, ti_r} + 1'b1))
      term = term + (p_iw >>> 17);
  end

  // Scale product in two halves: low word of the sum first, high word next cycle.
  assign p_lo = 65'($signed({1'b0, acc_r[31:0]})) * 65'(scale);
  assign p_hi = 64'($signed(acc_r[63:32])) * 64'(scale);
  assign p_full = (96'(p_hi) <<< 32) + 96'(plo_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid && q_cmd.op == OpQuery) state_nxt = ST_RD;
      ST_RD: begin
        if (!in_range_r) state_nxt = ST_OUT;
        else if (last_rd) state_nxt = ST_TERM;
      end
      ST_TERM: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop = (state_r == ST_IDLE) && q_valid;
    out_tvalid = (state_r == ST_OUT);
    out_tdata = {4'd0, val_r[31:0], cmd_r.col, cmd_r.row};
    out_tlast = cmd_r.fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath: one store read per cycle in the read state, accumulated in the cycle after.
  always_ff @(posedge clk) begin
    rd_v_r <= (state_r == ST_RD) && in_range_r;
    ti_r <= ri;
    tj_r <= rj;
    if (q_pop && q_cmd.op == OpQuery) begin
      cmd_r <= q_cmd;
      act_r <= act_clip;
      l_r <= '0;
      phase_r <= 1'b0;
      acc_r <= '0;
      in_range_r <= ({1'b0, q_cmd.row} < 7'(act_clip)) && ({1'b0, q_cmd.col} < 7'(act_clip));
      val_r <= '0;
    end else begin
      if (state_r == ST_RD) begin
        if (diag) begin
          phase_r <= ~phase_r;
          if (phase_r) l_r <= l_r + CntW'(1);
        end else phase_r <= 1'b1;
      end
      if (rd_v_r) acc_r <= diag ? acc_r + term : acc_r - term;
      if (state_r == ST_MUL) plo_r <= p_lo;
      if (state_r == ST_SCALE && in_range_r)
        val_r <= sat32((p_full >>> 16) +
                 ((diag && cmd_r.row == 6'd0) ? 96'(DiagZeroOffset) : 96'sd0));
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE)) else $error("pop while busy");
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !in_range_r) |-> (out_tdata[43:12] == 32'd0))
    else $error("out of range query gave nonzero value");

endmodule
